FILE: rtl/lgcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgcd_pkg
// Packet kinds, driver register codes and helpers for the LED grid
// command decoder.
// ----------------------------------------------------------------------------
package lgcd_pkg;

  localparam logic [3:0] KIND_LED_ON    = 4'd2;
  localparam logic [3:0] KIND_LED_OFF   = 4'd3;
  localparam logic [3:0] KIND_ROW       = 4'd4;
  localparam logic [3:0] KIND_COL       = 4'd5;
  localparam logic [3:0] KIND_ROW_BOTH  = 4'd6;
  localparam logic [3:0] KIND_COL_LONG  = 4'd7;
  localparam logic [3:0] KIND_FRAME     = 4'd8;
  localparam logic [3:0] KIND_CLEAR     = 4'd9;
  localparam logic [3:0] KIND_INTENSITY = 4'd10;
  localparam logic [3:0] KIND_MODE      = 4'd11;
  localparam logic [3:0] KIND_TILT      = 4'd12;
  localparam logic [3:0] KIND_COUNT     = 4'd13;

  localparam logic [3:0] REG_INTENSITY  = 4'd10;
  localparam logic [3:0] REG_SHUTDOWN   = 4'd12;
  localparam logic [3:0] REG_TEST       = 4'd15;

  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_TEST      = 2'd1;
  localparam logic [1:0] MODE_SHUTDOWN  = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  localparam logic [7:0] TIMEOUT_RESET  = 8'd40;

  function automatic logic [3:0] pkt_len(input logic [3:0] kind);
    logic [3:0] len;
    case (kind) inside
      [4'd0:4'd5]:               len = 4'd2;
      KIND_ROW_BOTH, KIND_COL_LONG: len = 4'd3;
      KIND_FRAME:                len = 4'd9;
      default:                   len = 4'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/led_grid_command_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_grid_command_decoder
// Assembles command bytes into packets, keeps the display in two banked
// memories and emits LED driver words.
// ----------------------------------------------------------------------------
// Tick or non-final byte: busy stays low. Final byte: dispatch sets the
// first word (intensity, mode), row pass after a bank read (row, column,
// frame, clear) or a write and re-read (LED on/off); eight-row commands
// give one word per cycle, set by one row read a cycle from the two banks.
// busy stays high until the cycle after the last word; results never stall.
// Reset clears control state and display valid bits; timeout_limit goes to 40.
module led_grid_command_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  output logic        strobe,
  output logic [3:0]  driver_reg,
  output logic [7:0]  data_first,
  output logic [7:0]  data_second,
  output logic        tilt_enable,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lgcd_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_LED_WR    = 3'd2;
  localparam logic [2:0] S_ROW_FIRST = 3'd3;
  localparam logic [2:0] S_ROW_PASS  = 3'd4;
  localparam logic [2:0] S_MODE2     = 3'd5;

  logic [2:0] state, state_next;
  logic [3:0] byte_count;
  logic [3:0] expected_length;
  logic [3:0] packet_kind;
  logic [7:0] idle_ticks;
  logic       tilt_flag;
  logic [7:0] timeout_limit;
  logic [2:0] cur_row, cur_row_next;
  logic       pass_all, pass_all_next;
  logic [7:0] packet_bytes [9];

  // bank a holds halves 0 and 2, bank b halves 1 and 3; address {h[1], row}
  logic [7:0] mem_a [16];
  logic [7:0] mem_b [16];
  logic [15:0] vld_a, vld_b;
  logic [7:0] rd_a, rd_b;
  logic       rd_a_vld, rd_b_vld;
  logic [3:0] rd_addr, wr_addr;
  logic       wr_a, wr_b;
  logic [7:0] wd_a, wd_b;

  logic       accept, cfg_wr;
  logic [3:0] cnt_cur, cnt_new, len_new, kind_new, first_type;
  logic       first_ok, complete;

  logic       emit, emit_last;
  logic [3:0] emit_reg;
  logic [7:0] emit_d1, emit_d2;

  logic [7:0] b0, b1, b2;
  logic [7:0] old_a, old_b, led_old, led_new, led_mask;
  logic [7:0] col_mask, col_old, col_new, new_a, new_b;
  logic       led_h0, led_h1, last_row;
  logic [3:0] frame_idx;

  assign pready      = 1'b1;
  assign tilt_enable = tilt_flag;
  assign busy        = (state != S_IDLE) || strobe;
  assign accept      = start && !busy;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign prdata      = paddr[2] ? 32'd0 : {24'd0, timeout_limit};

  assign b0 = packet_bytes[0];
  assign b1 = packet_bytes[1];
  assign b2 = packet_bytes[2];

  // packet assembly
  always_comb begin
    cnt_cur    = (byte_count > 4'd8) ? 4'd0 : byte_count;
    first_type = rx_byte[7:4];
    first_ok   = first_type < KIND_COUNT;
    kind_new   = packet_kind;
    len_new    = expected_length;
    cnt_new    = cnt_cur + 4'd1;
    if (cnt_cur == 4'd0) begin
      if (first_ok) begin
        kind_new = first_type;
        len_new  = pkt_len(first_type);
        cnt_new  = 4'd1;
      end else begin
        cnt_new  = 4'd0;
      end
    end
    complete = (cnt_new != 4'd0) && (cnt_new == len_new);
  end

  // display datapath
  always_comb begin
    old_a    = rd_a_vld ? rd_a : 8'd0;
    old_b    = rd_b_vld ? rd_b : 8'd0;
    led_h0   = b1[7];
    led_h1   = b1[3];
    led_mask = 8'd1 << b1[6:4];
    led_old  = led_h0 ? old_b : old_a;
    led_new  = (packet_kind == KIND_LED_ON) ? (led_old | led_mask) : (led_old & ~led_mask);
    col_mask = 8'd1 << b0[2:0];
    col_old  = b0[3] ? old_b : old_a;
    col_new  = b1[cur_row] ? (col_old | col_mask) : (col_old & ~col_mask);
    frame_idx = {1'b0, cur_row} + 4'd1;
    new_a    = old_a;
    new_b    = old_b;
    case (packet_kind)
      KIND_ROW: begin
        new_a = b1;
      end
      KIND_ROW_BOTH: begin
        new_a = b1;
        new_b = b2;
      end
      KIND_COL, KIND_COL_LONG: begin
        if (b0[3]) new_b = col_new;
        else       new_a = col_new;
      end
      KIND_FRAME: begin
        if (b0[0]) new_b = packet_bytes[frame_idx];
        else       new_a = packet_bytes[frame_idx];
      end
      KIND_CLEAR: begin
        new_a = {8{b0[0]}};
        new_b = {8{b0[0]}};
      end
      default: begin
      end
    endcase
    last_row = !pass_all || (cur_row == 3'd7);
  end

  // sequencer
  always_comb begin
    state_next    = state;
    cur_row_next  = cur_row;
    pass_all_next = pass_all;
    rd_addr       = {1'b0, cur_row};
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    wr_addr       = {1'b0, cur_row};
    wd_a          = new_a;
    wd_b          = new_b;
    emit          = 1'b0;
    emit_last     = 1'b0;
    emit_reg      = {1'b0, cur_row} + 4'd1;
    emit_d1       = flip8(new_a);
    emit_d2       = flip8(new_b);
    case (state)
      S_IDLE: begin
        if (accept && !op && complete) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        case (packet_kind)
          KIND_LED_ON, KIND_LED_OFF: begin
            rd_addr       = {led_h1, b1[2:0]};
            cur_row_next  = b1[2:0];
            pass_all_next = 1'b0;
            state_next    = S_LED_WR;
          end
          KIND_ROW, KIND_ROW_BOTH: begin
            if (b0[3:0] <= 4'd7) begin
              rd_addr       = {1'b0, b0[2:0]};
              cur_row_next  = b0[2:0];
              pass_all_next = 1'b0;
              state_next    = S_ROW_PASS;
            end
          end
          KIND_COL, KIND_COL_LONG, KIND_CLEAR, KIND_FRAME: begin
            if (packet_kind != KIND_FRAME || !b0[1]) begin
              rd_addr       = 4'd0;
              cur_row_next  = 3'd0;
              pass_all_next = 1'b1;
              state_next    = S_ROW_PASS;
            end
          end
          KIND_INTENSITY: begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_reg  = REG_INTENSITY;
            emit_d1   = {4'd0, b0[3:0]};
            emit_d2   = {4'd0, b0[3:0]};
          end
          KIND_MODE: begin
            if (b0[1:0] != MODE_NONE) begin
              emit       = 1'b1;
              emit_reg   = REG_SHUTDOWN;
              emit_d1    = (b0[1:0] == MODE_SHUTDOWN) ? 8'd0 : 8'd1;
              emit_d2    = emit_d1;
              state_next = S_MODE2;
            end
          end
          default: begin
          end
        endcase
      end
      S_LED_WR: begin
        wr_addr    = {led_h1, b1[2:0]};
        wd_a       = led_new;
        wd_b       = led_new;
        wr_a       = !led_h0;
        wr_b       = led_h0;
        state_next = S_ROW_FIRST;
      end
      S_ROW_FIRST: begin
        state_next = S_ROW_PASS;
      end
      S_ROW_PASS: begin
        wr_a      = (packet_kind == KIND_ROW) || (packet_kind == KIND_ROW_BOTH) ||
                    (packet_kind == KIND_CLEAR) ||
                    (((packet_kind == KIND_COL) || (packet_kind == KIND_COL_LONG)) && !b0[3]) ||
                    ((packet_kind == KIND_FRAME) && !b0[0]);
        wr_b      = (packet_kind == KIND_ROW_BOTH) || (packet_kind == KIND_CLEAR) ||
                    (((packet_kind == KIND_COL) || (packet_kind == KIND_COL_LONG)) && b0[3]) ||
                    ((packet_kind == KIND_FRAME) && b0[0]);
        emit      = 1'b1;
        emit_last = last_row;
        rd_addr   = {1'b0, cur_row + 3'd1};
        if (last_row) begin
          state_next = S_IDLE;
        end else begin
          cur_row_next = cur_row + 3'd1;
        end
      end
      S_MODE2: begin
        emit       = 1'b1;
        emit_last  = 1'b1;
        emit_reg   = REG_TEST;
        emit_d1    = (b0[1:0] == MODE_TEST) ? 8'd1 : 8'd0;
        emit_d2    = emit_d1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      byte_count      <= 4'd0;
      expected_length <= 4'd1;
      packet_kind     <= 4'd0;
      idle_ticks      <= 8'd0;
      tilt_flag       <= 1'b0;
      timeout_limit   <= TIMEOUT_RESET;
      cur_row         <= 3'd0;
      pass_all        <= 1'b0;
      strobe          <= 1'b0;
      vld_a           <= '0;
      vld_b           <= '0;
    end else begin
      state    <= state_next;
      cur_row  <= cur_row_next;
      pass_all <= pass_all_next;
      strobe   <= emit;
      if (cfg_wr && !paddr[2]) timeout_limit <= pwdata[7:0];
      if (accept) begin
        if (op) begin
          if (idle_ticks > timeout_limit) byte_count <= 4'd0;
          else                            idle_ticks <= idle_ticks + 8'd1;
        end else begin
          packet_kind     <= kind_new;
          expected_length <= len_new;
          byte_count      <= complete ? 4'd0 : cnt_new;
          if (cnt_cur == 4'd0 && first_ok) idle_ticks <= 8'd0;
        end
      end
      if (state == S_DISPATCH && packet_kind == KIND_TILT) tilt_flag <= b0[0];
      if (wr_a) vld_a[wr_addr] <= 1'b1;
      if (wr_b) vld_b[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !op) packet_bytes[cnt_cur] <= rx_byte;
    if (emit) begin
      driver_reg  <= emit_reg;
      data_first  <= emit_d1;
      data_second <= emit_d2;
      last        <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_a[wr_addr] <= wd_a;
    if (wr_b) mem_b[wr_addr] <= wd_b;
    rd_a     <= mem_a[rd_addr];
    rd_b     <= mem_b[rd_addr];
    rd_a_vld <= vld_a[rd_addr];
    rd_b_vld <= vld_b[rd_addr];
  end

endmodule

FILE: rtl/lgcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgcd_checker
// Port-level checks on word sequencing of the LED grid command decoder.
// ----------------------------------------------------------------------------
module lgcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [3:0] driver_reg,
  input logic [7:0] data_first,
  input logic [7:0] data_second,
  input logic       tilt_enable,
  input logic       last
);
  import lgcd_pkg::*;

  a_no_word_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe)
    else $error("word right after accept");

  a_words_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (strobe && $stable(tilt_enable)))
    else $error("gap or tilt change inside a word burst");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("word after last");

  a_intensity_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && driver_reg == REG_INTENSITY) |-> (last && data_first == data_second))
    else $error("bad intensity word");

  a_busy_with_word: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("word while not busy");

endmodule

bind led_grid_command_decoder lgcd_checker u_lgcd_checker (.*);
